[hw/rtl/bfd_pkg.sv]
package bfd_pkg;

	localparam int MAX_OUT_WIDTH  = 256;
	localparam int MAX_SCALE      = 16;
	localparam int MAX_OUT_HEIGHT = 4095;
	localparam int MAX_ROW_PIXELS = 4096;

	localparam int SCALE_W    = 5;
	localparam int OUT_W_W    = 9;
	localparam int OUT_H_W    = 12;
	localparam int ROW_W      = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;

	localparam int COLOR_W = 8;
	localparam int SUB_W   = $clog2(MAX_SCALE);
	localparam int INCOL_W = ROW_W - 1;
	// block sum; saturates at all ones, which is past 255 * scale * scale
	localparam int SUM_W       = $clog2(MAX_SCALE * MAX_SCALE * 255 + 1);
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = SUM_W + RECIP_W;
	localparam int MEAN_W      = PROD_W - RECIP_SHIFT;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCALE      = 2'd0,
		CFG_OUT_WIDTH  = 2'd1,
		CFG_OUT_HEIGHT = 2'd2,
		CFG_ROW_PIXELS = 2'd3
	} cfg_reg_e;

	typedef struct packed {
		logic [SCALE_W-1:0] scale;
		logic [OUT_W_W-1:0] out_width;
		logic [OUT_H_W-1:0] out_height;
		logic [ROW_W-1:0]   row_pixels;
	} cfg_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               start_of_frame;
	} pix_in_t;

	typedef struct packed {
		logic [COLOR_W-1:0] avg_red;
		logic [COLOR_W-1:0] avg_green;
		logic [COLOR_W-1:0] avg_blue;
		logic               frame_end;
	} pix_out_t;

	// accumulate request passed from front to back (column index travels beside it)
	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               first;
		logic               last;
		logic               frame_end;
	} op_t;

	typedef logic [2:0][SUM_W-1:0] sums_t;

	// ceil(2^24 / (s*s)) for s = 1..16; exact floor division for sums below 2^16
	localparam logic [RECIP_W-1:0] RECIP [MAX_SCALE] = '{
		25'd16777216, 25'd4194304, 25'd1864136, 25'd1048576,
		25'd671089,   25'd466034,  25'd342393,  25'd262144,
		25'd207127,   25'd167773,  25'd138655,  25'd116509,
		25'd99274,    25'd85599,   25'd74566,   25'd65536
	};

	function automatic logic [SCALE_W-1:0] scale_eff(input logic [SCALE_W-1:0] s);
		logic [SCALE_W-1:0] r;
		if (s == '0) begin
			r = SCALE_W'(1);
		end else if (s > SCALE_W'(MAX_SCALE)) begin
			r = SCALE_W'(MAX_SCALE);
		end else begin
			r = s;
		end
		return r;
	endfunction

endpackage

[hw/rtl/box_filter_downsampler.sv]
// Channel   Signals                         Carries
// ------    ------------------------------  -------------------------------------
// pixel     px_valid / px_ready / px        RGB pixel, raster order, start_of_frame
// average   res_valid / res_ready / res     block mean per channel, frame_end
// config    cfg_write / cfg_index / cfg_data register write, no wait, no read-back
//
// One pixel per clock sustained unless the average channel stalls; the line store takes
// one read and one write per cycle. A block mean leaves through the queue, line store read,
// sum register, multiply and output register after its bottom-right pixel is taken.
// Reset clears counters, queue, pipeline and line store valid bits; registers go to
// scale 1, 160x120 output, 160-pixel rows.
// A 4-request queue parts the counters from the accumulate path, so either side stalls alone.
module box_filter_downsampler #(
	parameter int MAX_OUT_WIDTH = bfd_pkg::MAX_OUT_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [bfd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bfd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               px_valid,
	output logic                               px_ready,
	input  bfd_pkg::pix_in_t                   px,
	output logic                               res_valid,
	input  logic                               res_ready,
	output bfd_pkg::pix_out_t                  res
);

	localparam int IDX_W = $clog2(MAX_OUT_WIDTH);
	localparam int OP_W  = $bits(bfd_pkg::op_t);
	localparam int Q_W   = IDX_W + OP_W;

	bfd_pkg::cfg_t    cfg_q;

	logic             push;
	logic [IDX_W-1:0] push_idx;
	bfd_pkg::op_t     push_op;
	logic             q_ready;
	logic             q_valid;
	logic             q_pop;
	logic [Q_W-1:0]   q_data;
	logic [IDX_W-1:0] q_idx;
	bfd_pkg::op_t     q_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale      <= bfd_pkg::SCALE_W'(1);
			cfg_q.out_width  <= bfd_pkg::OUT_W_W'(160);
			cfg_q.out_height <= bfd_pkg::OUT_H_W'(120);
			cfg_q.row_pixels <= bfd_pkg::ROW_W'(160);
		end else if (cfg_write) begin
			unique case (cfg_index)
				bfd_pkg::CFG_SCALE: begin
					cfg_q.scale <= cfg_data[bfd_pkg::SCALE_W-1:0];
				end
				bfd_pkg::CFG_OUT_WIDTH: begin
					cfg_q.out_width <= cfg_data[bfd_pkg::OUT_W_W-1:0];
				end
				bfd_pkg::CFG_OUT_HEIGHT: begin
					cfg_q.out_height <= cfg_data[bfd_pkg::OUT_H_W-1:0];
				end
				bfd_pkg::CFG_ROW_PIXELS: begin
					cfg_q.row_pixels <= cfg_data[bfd_pkg::ROW_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	bfd_front #(
		.MAX_OUT_WIDTH(MAX_OUT_WIDTH),
		.IDX_W        (IDX_W)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.px_valid(px_valid),
		.px_ready(px_ready),
		.px      (px),
		.push    (push),
		.push_idx(push_idx),
		.push_op (push_op),
		.q_ready (q_ready)
	);

	bfd_queue #(
		.W    (Q_W),
		.DEPTH(bfd_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata ({push_idx, push_op}),
		.ready (q_ready),
		.pop   (q_pop),
		.valid (q_valid),
		.rdata (q_data)
	);

	assign q_idx = q_data[Q_W-1:OP_W];
	assign q_op  = bfd_pkg::op_t'(q_data[OP_W-1:0]);

	bfd_back #(
		.MAX_OUT_WIDTH(MAX_OUT_WIDTH),
		.IDX_W        (IDX_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_idx    (q_idx),
		.q_op     (q_op),
		.q_pop    (q_pop),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

endmodule

[hw/rtl/bfd_queue.sv]
module bfd_queue #(
	parameter int W     = 32,
	parameter int DEPTH = bfd_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         ready,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign ready   = (count_q != CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign rdata   = store_q[rd_ptr_q];
	assign do_push = push && ready;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/bfd_front.sv]
module bfd_front #(
	parameter int MAX_OUT_WIDTH = bfd_pkg::MAX_OUT_WIDTH,
	parameter int IDX_W         = $clog2(MAX_OUT_WIDTH)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bfd_pkg::cfg_t           cfg,
	input  logic                    px_valid,
	output logic                    px_ready,
	input  bfd_pkg::pix_in_t        px,
	output logic                    push,
	output logic [IDX_W-1:0]        push_idx,
	output bfd_pkg::op_t            push_op,
	input  logic                    q_ready
);

	localparam int COL_W = $clog2(MAX_OUT_WIDTH + 1);
	localparam int OWC_W = (COL_W > bfd_pkg::OUT_W_W) ? COL_W : bfd_pkg::OUT_W_W;
	localparam int SW    = bfd_pkg::SCALE_W;
	localparam int HW    = bfd_pkg::OUT_H_W;
	localparam int RW    = bfd_pkg::ROW_W;
	localparam int ICW   = bfd_pkg::INCOL_W;
	localparam int SBW   = bfd_pkg::SUB_W;

	logic [ICW-1:0]   in_column_q;
	logic [SBW-1:0]   sub_column_q;
	logic [COL_W-1:0] out_column_q;
	logic [SBW-1:0]   sub_row_q;
	logic [HW-1:0]    out_row_q;
	logic             frame_done_q;

	logic [SW-1:0]    s;
	logic [OWC_W-1:0] ow;
	logic [HW-1:0]    oh;
	logic [RW-1:0]    rp;

	logic [ICW-1:0]   ic;
	logic [SBW-1:0]   sc;
	logic [COL_W-1:0] oc;
	logic [SBW-1:0]   sr;
	logic [HW-1:0]    orow;
	logic             fd;

	logic [RW-1:0]    ic_inc;
	logic [SW-1:0]    sc_inc;
	logic [SW-1:0]    sr_inc;
	logic             col_ok;
	logic             row_ok;
	logic             first;
	logic             last;
	logic             accept;

	logic [ICW-1:0]   ic_nxt;
	logic [SBW-1:0]   sc_nxt;
	logic [COL_W-1:0] oc_nxt;
	logic [SBW-1:0]   sr_nxt;
	logic [HW-1:0]    orow_nxt;

	always_comb begin
		s  = bfd_pkg::scale_eff(cfg.scale);
		ow = OWC_W'(cfg.out_width);
		if (ow == '0) begin
			ow = OWC_W'(1);
		end else if (ow > OWC_W'(MAX_OUT_WIDTH)) begin
			ow = OWC_W'(MAX_OUT_WIDTH);
		end
		oh = (cfg.out_height == '0) ? HW'(1) : cfg.out_height;
		rp = cfg.row_pixels;
		if (rp == '0) begin
			rp = RW'(1);
		end else if (rp > RW'(bfd_pkg::MAX_ROW_PIXELS)) begin
			rp = RW'(bfd_pkg::MAX_ROW_PIXELS);
		end
	end

	// start of frame clears the position before the pixel is placed
	always_comb begin
		if (px.start_of_frame) begin
			ic   = '0;
			sc   = '0;
			oc   = '0;
			sr   = '0;
			orow = '0;
			fd   = 1'b0;
		end else begin
			ic   = in_column_q;
			sc   = sub_column_q;
			oc   = out_column_q;
			sr   = sub_row_q;
			orow = out_row_q;
			fd   = frame_done_q;
		end
	end

	assign col_ok = (OWC_W'(oc) < ow);
	assign row_ok = (orow < oh);
	assign first  = (sr == '0) && (sc == '0);
	assign last   = (SW'(sr) == s - 1'b1) && (SW'(sc) == s - 1'b1);

	assign px_ready = q_ready;
	assign accept   = px_valid && px_ready;
	assign push     = accept && !fd && col_ok && row_ok;
	assign push_idx = oc[IDX_W-1:0];

	always_comb begin
		push_op.red       = px.red;
		push_op.green     = px.green;
		push_op.blue      = px.blue;
		push_op.first     = first;
		push_op.last      = last;
		push_op.frame_end = last && (OWC_W'(oc) == ow - 1'b1) && (orow == oh - 1'b1);
	end

	always_comb begin
		ic_inc   = RW'(ic) + 1'b1;
		sc_inc   = SW'(sc) + 1'b1;
		sr_inc   = SW'(sr) + 1'b1;
		ic_nxt   = ic;
		sc_nxt   = sc;
		oc_nxt   = oc;
		sr_nxt   = sr;
		orow_nxt = orow;
		if (!fd) begin
			if (ic_inc >= rp) begin
				ic_nxt = '0;
				sc_nxt = '0;
				oc_nxt = '0;
				if (sr_inc >= s) begin
					sr_nxt = '0;
					if (row_ok) begin
						orow_nxt = orow + 1'b1;
					end
				end else begin
					sr_nxt = sr_inc[SBW-1:0];
				end
			end else begin
				ic_nxt = ic_inc[ICW-1:0];
				if (sc_inc >= s) begin
					sc_nxt = '0;
					if (col_ok) begin
						oc_nxt = oc + 1'b1;
					end
				end else begin
					sc_nxt = sc_inc[SBW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_column_q  <= '0;
			sub_column_q <= '0;
			out_column_q <= '0;
			sub_row_q    <= '0;
			out_row_q    <= '0;
			frame_done_q <= 1'b0;
		end else if (accept) begin
			in_column_q  <= ic_nxt;
			sub_column_q <= sc_nxt;
			out_column_q <= oc_nxt;
			sub_row_q    <= sr_nxt;
			out_row_q    <= orow_nxt;
			frame_done_q <= fd || (push && push_op.frame_end);
		end
	end

endmodule

[hw/rtl/bfd_back.sv]
module bfd_back #(
	parameter int MAX_OUT_WIDTH = bfd_pkg::MAX_OUT_WIDTH,
	parameter int IDX_W         = $clog2(MAX_OUT_WIDTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bfd_pkg::cfg_t        cfg,
	input  logic                 q_valid,
	input  logic [IDX_W-1:0]     q_idx,
	input  bfd_pkg::op_t         q_op,
	output logic                 q_pop,
	output logic                 res_valid,
	input  logic                 res_ready,
	output bfd_pkg::pix_out_t    res
);

	localparam int SUM_W  = bfd_pkg::SUM_W;
	localparam int PROD_W = bfd_pkg::PROD_W;
	localparam int MEAN_W = bfd_pkg::MEAN_W;
	localparam int CW     = bfd_pkg::COLOR_W;
	localparam int SW     = bfd_pkg::SCALE_W;

	// line store of per-column block sums, valid bit per entry
	bfd_pkg::sums_t mem [MAX_OUT_WIDTH];
	logic [MAX_OUT_WIDTH-1:0] valid_q;

	logic                 v_s1;
	logic [IDX_W-1:0]     idx_s1;
	bfd_pkg::op_t         op_s1;
	bfd_pkg::sums_t       rd_s1;
	logic                 rdv_s1;

	logic                 fwd_v_q;
	logic [IDX_W-1:0]     fwd_idx_q;
	bfd_pkg::sums_t       fwd_sum_q;

	logic                 v_s2;
	bfd_pkg::sums_t       sum_s2;
	logic                 fe_s2;

	logic                 v_s3;
	logic [2:0][PROD_W-1:0] prod_s3;
	logic                 fe_s3;

	logic                 res_valid_q;
	bfd_pkg::pix_out_t    res_q;

	logic                 out_take;
	logic                 go_s3;
	logic                 free_s3;
	logic                 go_s2;
	logic                 free_s2;
	logic                 go_s1;
	logic                 free_s1;

	bfd_pkg::sums_t       base;
	bfd_pkg::sums_t       sum_new;
	logic [2:0][CW-1:0]   px;
	logic [SUM_W:0]       add_w;
	logic [SW-1:0]        s;
	logic [bfd_pkg::RECIP_W-1:0] recip;
	logic [2:0][MEAN_W-1:0] mean;
	logic [2:0][CW-1:0]   avg;

	assign out_take = !res_valid_q || res_ready;
	assign go_s3    = v_s3 && out_take;
	assign free_s3  = !v_s3 || go_s3;
	assign go_s2    = v_s2 && free_s3;
	assign free_s2  = !v_s2 || go_s2;
	// a non-final request retires with its write; a final one also waits for stage 2 to be free
	assign go_s1    = v_s1 && (!op_s1.last || free_s2);
	assign free_s1  = !v_s1 || go_s1;
	assign q_pop    = q_valid && free_s1;

	// read-modify-write; bypass the write made in the cycle of this read
	always_comb begin
		px[0] = op_s1.red;
		px[1] = op_s1.green;
		px[2] = op_s1.blue;
		if (fwd_v_q && fwd_idx_q == idx_s1) begin
			base = fwd_sum_q;
		end else if (rdv_s1) begin
			base = rd_s1;
		end else begin
			base = '0;
		end
		add_w = '0;
		for (int c = 0; c < 3; c++) begin
			if (op_s1.first) begin
				sum_new[c] = SUM_W'(px[c]);
			end else begin
				add_w = {1'b0, base[c]} + (SUM_W + 1)'(px[c]);
				sum_new[c] = add_w[SUM_W] ? '1 : add_w[SUM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			mem[idx_s1] <= sum_new;
		end
		if (q_pop) begin
			rd_s1  <= mem[q_idx];
			rdv_s1 <= valid_q[q_idx];
			idx_s1 <= q_idx;
			op_s1  <= q_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			v_s1    <= 1'b0;
			fwd_v_q <= 1'b0;
		end else begin
			if (go_s1) begin
				valid_q[idx_s1] <= 1'b1;
				fwd_v_q         <= 1'b1;
			end
			if (free_s1) begin
				v_s1 <= q_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			fwd_idx_q <= idx_s1;
			fwd_sum_q <= sum_new;
		end
	end

	// division by scale*scale as a multiply by the reciprocal
	assign s     = bfd_pkg::scale_eff(cfg.scale);
	assign recip = bfd_pkg::RECIP[s[SW-2:0] - 1'b1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (free_s2) begin
				v_s2 <= go_s1 && op_s1.last;
			end
			if (free_s3) begin
				v_s3 <= go_s2;
			end
			if (out_take) begin
				res_valid_q <= go_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free_s2 && go_s1 && op_s1.last) begin
			sum_s2 <= sum_new;
			fe_s2  <= op_s1.frame_end;
		end
		if (go_s2) begin
			for (int c = 0; c < 3; c++) begin
				prod_s3[c] <= PROD_W'(sum_s2[c]) * PROD_W'(recip);
			end
			fe_s3 <= fe_s2;
		end
		if (go_s3) begin
			res_q.avg_red   <= avg[0];
			res_q.avg_green <= avg[1];
			res_q.avg_blue  <= avg[2];
			res_q.frame_end <= fe_s3;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			mean[c] = prod_s3[c][PROD_W-1:bfd_pkg::RECIP_SHIFT];
			avg[c]  = (mean[c] > MEAN_W'(255)) ? '1 : mean[c][CW-1:0];
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[tb/box_filter_downsampler_tb.sv]
module box_filter_downsampler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bfd_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RANDOM_PIXELS = 40;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_SCALE;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  px_valid  = 1'b0;
	logic                  px_ready;
	pix_in_t               px        = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	pix_out_t              res;

	// predictor copy of registers, counters and line store
	logic [SCALE_W-1:0] scale_r;
	logic [OUT_W_W-1:0] out_width_r;
	logic [OUT_H_W-1:0] out_height_r;
	logic [ROW_W-1:0]   row_pixels_r;
	int unsigned        col_sums [MAX_OUT_WIDTH][3];
	int unsigned        in_col, sub_col, out_col, sub_row, out_row;
	bit                 frame_closed;

	pix_out_t    pending_means [$];
	int unsigned errors        = 0;
	int unsigned pixels_taken  = 0;
	int unsigned means_checked = 0;
	int unsigned frames_closed = 0;
	int unsigned reg_writes    = 0;
	int unsigned cycle_count   = 0;

	// sender bursts and receiver stall pattern
	int tx_mode     = 0;
	int burst_left  = 0;
	int rx_mode     = 0;
	int ready_run   = 0;
	bit ready_level = 1'b1;

	box_filter_downsampler i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.px_valid  (px_valid),
		.px_ready  (px_ready),
		.px        (px),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d block means still pending", $time, pending_means.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int unsigned clamp_u(input int unsigned v, input int unsigned lo,
			input int unsigned hi);
		if (v < lo) begin
			return lo;
		end
		return (v > hi) ? hi : v;
	endfunction

	function automatic void reset_predictor();
		foreach (col_sums[i, c]) begin
			col_sums[i][c] = 0;
		end
		{in_col, sub_col, out_col, sub_row, out_row} = '0;
		frame_closed = 1'b0;
		scale_r      = SCALE_W'(1);
		out_width_r  = OUT_W_W'(160);
		out_height_r = OUT_H_W'(120);
		row_pixels_r = ROW_W'(160);
	endfunction

	// accumulate one accepted pixel; queue a block mean when its bottom-right pixel lands
	function automatic void take_pixel(input pix_in_t p);
		int unsigned s, ow, oh, rp, area, m, c;
		int unsigned chan [3];
		bit          first;
		pix_out_t    r;
		s  = clamp_u(32'(scale_r), 1, MAX_SCALE);
		ow = clamp_u(32'(out_width_r), 1, MAX_OUT_WIDTH);
		oh = clamp_u(32'(out_height_r), 1, MAX_OUT_HEIGHT);
		rp = clamp_u(32'(row_pixels_r), 1, MAX_ROW_PIXELS);
		chan[0] = 32'(p.red);
		chan[1] = 32'(p.green);
		chan[2] = 32'(p.blue);
		if (p.start_of_frame) begin
			{in_col, sub_col, out_col, sub_row, out_row} = '0;
			frame_closed = 1'b0;
		end
		if (frame_closed) begin
			return;
		end
		if (out_col < ow && out_row < oh) begin
			first = (sub_row == 0 && sub_col == 0);
			for (c = 0; c < 3; c++) begin
				col_sums[out_col][c] = first ? chan[c] : col_sums[out_col][c] + chan[c];
			end
			if (sub_row == s - 1 && sub_col == s - 1) begin
				area = s * s;
				for (c = 0; c < 3; c++) begin
					m = col_sums[out_col][c] / area;
					chan[c] = (m > 255) ? 255 : m;
				end
				r.avg_red   = COLOR_W'(chan[0]);
				r.avg_green = COLOR_W'(chan[1]);
				r.avg_blue  = COLOR_W'(chan[2]);
				r.frame_end = (out_col == ow - 1 && out_row == oh - 1);
				if (r.frame_end) begin
					frame_closed = 1'b1;
				end
				pending_means.insert(pending_means.size(), r);
			end
		end
		in_col++;
		if (in_col >= rp) begin
			in_col  = 0;
			sub_col = 0;
			out_col = 0;
			sub_row++;
			if (sub_row >= s) begin
				sub_row = 0;
				if (out_row < oh) begin
					out_row++;
				end
			end
		end else begin
			sub_col++;
			if (sub_col >= s) begin
				sub_col = 0;
				if (out_col < ow) begin
					out_col++;
				end
			end
		end
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : result_sink
		pix_out_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_means.size() == 0) begin
				$display("%0t: unexpected block mean, expected none, got %p", $time, res);
				errors++;
			end else begin
				want = pending_means.pop_front();
				check_field("avg_red", 32'(want.avg_red), 32'(res.avg_red));
				check_field("avg_green", 32'(want.avg_green), 32'(res.avg_green));
				check_field("avg_blue", 32'(want.avg_blue), 32'(res.avg_blue));
				check_field("frame_end", 32'(want.frame_end), 32'(res.frame_end));
				means_checked++;
				if (res.frame_end) begin
					frames_closed++;
				end
			end
		end
		if (ready_run == 0) begin
			case (rx_mode)
				0: begin
					ready_level = 1'b1;
					ready_run   = 8;
				end
				1: begin
					ready_level = 1'($urandom_range(0, 1));
					ready_run   = $urandom_range(0, 2);
				end
				default: begin
					ready_level = !ready_level;
					ready_run   = ready_level ? $urandom_range(1, 12) : $urandom_range(1, 20);
				end
			endcase
		end else begin
			ready_run--;
		end
		res_ready <= ready_level;
	end

	task automatic send_pixel(input pix_in_t p);
		int gap;
		if (tx_mode != 0) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap        = $urandom_range(1, 6);
				px_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left--;
		end
		px_valid <= 1'b1;
		px       <= p;
		do @(posedge clk); while (!px_ready);
		take_pixel(p);
		pixels_taken++;
	endtask

	// stop sending, let every pending mean arrive, then let the pipeline settle
	task automatic drain();
		px_valid <= 1'b0;
		while (pending_means.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input int unsigned vals [4], input bit [3:0] which);
		int i;
		for (i = 0; i < 4; i++) begin
			if (which[i]) begin
				cfg_write <= 1'b1;
				cfg_index <= CFG_IDX_W'(i);
				cfg_data  <= CFG_DATA_W'(vals[i]);
				@(posedge clk);
				case (cfg_reg_e'(i))
					CFG_SCALE:      scale_r      = SCALE_W'(vals[i]);
					CFG_OUT_WIDTH:  out_width_r  = OUT_W_W'(vals[i]);
					CFG_OUT_HEIGHT: out_height_r = OUT_H_W'(vals[i]);
					CFG_ROW_PIXELS: row_pixels_r = ROW_W'(vals[i]);
				endcase
				reg_writes++;
			end
		end
		cfg_write <= 1'b0;
	endtask

	function automatic logic [COLOR_W-1:0] pick_color();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return COLOR_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pix_in_t random_pixel();
		pix_in_t p;
		p.red            = pick_color();
		p.green          = pick_color();
		p.blue           = pick_color();
		p.start_of_frame = 1'b0;
		return p;
	endfunction

	task automatic send_pixels(input int unsigned n, input bit sof_first, input bit all_ones);
		pix_in_t     p;
		int unsigned k;
		for (k = 0; k < n; k++) begin
			p = all_ones ? pix_in_t'{'1, '1, '1, 1'b0} : random_pixel();
			p.start_of_frame = sof_first && (k == 0);
			send_pixel(p);
		end
	endtask

	task automatic test_reset_defaults();
		// scale 1 after reset: every pixel is its own block
		send_pixel('{8'hFF, 8'h00, 8'hAA, 1'b1});
		send_pixel('{8'h00, 8'hFF, 8'h55, 1'b0});
		send_pixel('{8'h80, 8'h7F, 8'h01, 1'b0});
		drain();
	endtask

	task automatic test_frame_end();
		pix_in_t p;
		int      k;
		write_regs('{2, 2, 1, 5}, 4'b1111);
		for (k = 0; k < 10; k++) begin
			p.red            = 8'hFF;
			p.green          = (k == 0) ? 8'h00 : 8'hFF;
			p.blue           = (k == 5) ? 8'h03 : 8'h00;
			p.start_of_frame = (k == 0);
			send_pixel(p);
		end
		// frame is closed: these two are dropped until the next start of frame
		send_pixels(2, 1'b0, 1'b0);
		send_pixels(1, 1'b1, 1'b1);
		drain();
	endtask

	task automatic test_short_rows();
		pix_in_t p;
		int      k;
		// row of 3 covers only the first 2x2 block, frame never ends
		write_regs('{2, 2, 1, 3}, 4'b1111);
		for (k = 0; k < 6; k++) begin
			p = (k % 2) ? pix_in_t'{'1, '0, '1, 1'b0} : pix_in_t'{'0, '1, '0, 1'b0};
			p.start_of_frame = (k == 0);
			send_pixel(p);
		end
		drain();
	endtask

	task automatic test_register_limits();
		int k;
		tx_mode = 1;
		rx_mode = 2;
		// all zero registers act as 1: each start of frame gives a one-pixel frame
		write_regs('{0, 0, 0, 0}, 4'b1111);
		for (k = 0; k < 6; k++) begin
			send_pixels(1, k % 2 == 0, 1'b0);
		end
		drain();
		// scale clamps to 16, one 16x16 block of full-scale pixels
		write_regs('{31, 1, 1, 16}, 4'b1111);
		send_pixels(256, 1'b1, 1'b1);
		drain();
		// out_width clamps to the line store size
		write_regs('{1, 511, 1, 256}, 4'b1111);
		send_pixels(256, 1'b1, 1'b0);
		drain();
		// tallest frame, only its first block row is sent
		rx_mode = 1;
		write_regs('{3, 2, 4095, 7}, 4'b1111);
		send_pixels(21, 1'b1, 1'b0);
		drain();
		write_regs('{16, 256, 1, 4096}, 4'b1111);
		send_pixels(16, 1'b1, 1'b0);
		drain();
	endtask

	task automatic test_midframe_writes();
		int unsigned vals [4];
		int          k;
		// shrinking the block after a full row overfills it: means saturate
		write_regs('{4, 3, 2, 12}, 4'b1111);
		send_pixels(12, 1'b1, 1'b1);
		drain();
		write_regs('{2, 0, 0, 0}, 4'b0001);
		send_pixels(36, 1'b0, 1'b1);
		drain();
		for (k = 0; k < 2; k++) begin
			tx_mode = $urandom_range(0, 1);
			rx_mode = $urandom_range(0, 2);
			vals = '{$urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 3), 0};
			vals[3] = vals[0] * vals[1] + $urandom_range(0, 2);
			write_regs(vals, 4'b1111);
			send_pixels($urandom_range(1, 20), 1'b1, 1'b0);
			drain();
			vals = '{$urandom_range(1, 5), $urandom_range(1, 6), $urandom_range(1, 4),
				$urandom_range(1, 20)};
			write_regs(vals, 4'b0001 << $urandom_range(0, 3));
			send_pixels($urandom_range(1, 30), 1'b0, $urandom_range(0, 3) == 0);
			drain();
		end
	endtask

	task automatic test_random_frames();
		int unsigned vals [4];
		int unsigned s, ow, oh, n, k, stray_sof, sent;
		int          kind;
		pix_in_t     p;
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			drain();
			if ($urandom_range(0, 9) == 0) begin
				s  = $urandom_range(5, 16);
				ow = 1;
				oh = 1;
			end else begin
				s  = $urandom_range(1, 4);
				ow = $urandom_range(1, 6);
				oh = $urandom_range(1, 4);
			end
			vals[0] = s;
			vals[1] = ow;
			vals[2] = oh;
			// now and then a row too short to cover every block
			vals[3] = ($urandom_range(0, 7) == 0) ? $urandom_range(1, ow * s)
				: ow * s + $urandom_range(0, 3);
			write_regs(vals, 4'b1111);
			tx_mode = ($urandom_range(0, 2) != 0) ? 1 : 0;
			rx_mode = $urandom_range(0, 2);
			repeat ($urandom_range(1, 3)) begin
				n         = vals[3] * oh * s;
				kind      = $urandom_range(0, 9);
				stray_sof = n;
				if (kind == 0) begin
					n = $urandom_range(1, n);
				end else if (kind == 1 && n > 1) begin
					stray_sof = $urandom_range(1, n - 1);
				end
				for (k = 0; k < n; k++) begin
					p = random_pixel();
					p.start_of_frame = (k == 0) || (k == stray_sof);
					send_pixel(p);
				end
				sent += n;
				if (kind >= 8) begin
					send_pixels($urandom_range(1, 4), 1'b0, 1'b0);
				end
			end
		end
		drain();
	endtask

	initial begin
		reset_predictor();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_frame_end();
		test_short_rows();
		test_register_limits();
		test_midframe_writes();
		test_random_frames();
		drain();
		$display("Covered %0d pixels, %0d block means checked, %0d complete frames,",
			pixels_taken, means_checked, frames_closed);
		$display("%0d register writes incl. out-of-range values and mid-frame changes.",
			reg_writes);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
